// File: rtl/ray_triangle_intersect_macros.svh
// Assertion macros for the ray/triangle intersection block.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH
`ifndef ASSERT_OFF
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RTI_ASSERT_ALWAYS(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cons)) else $error(msg);
`else
`define RTI_ASSERT_IMP(lbl, ante, cons, msg)
`define RTI_ASSERT_ALWAYS(lbl, cons, msg)
`endif
`endif

// File: rtl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection block.
package rti_pkg;
  typedef enum logic [1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2,
    REG_EPSILON  = 2'd3
  } reg_idx_t;
  localparam int TQ_BITS  = 32;
  localparam int UQ_BITS  = 16;
  localparam int EPS_BITS = 16;
  localparam int IO_BITS  = 16;
endpackage

// File: rtl/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle intersection test, fully pipelined.
// Rays are accepted on every cycle that start is high; busy is high only
// in reset. Each ray produces one result beat, marked by done: eight
// arithmetic stages form the origin offset, cross and dot products and
// accept tests, then 32 restoring-division stages produce the distance
// quotient one bit per stage (the barycentric quotients use the first 16),
// and an output register follows. Results cannot be held off by the receiver.
// Vertices and epsilon sit in an APB register file at byte offsets 0, 8,
// 16 and 24; write them only while no ray is in flight.
`include "ray_triangle_intersect_macros.svh"
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_WIDTH   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    origin_x,
  input  logic signed [15:0]    origin_y,
  input  logic signed [15:0]    origin_z,
  input  logic signed [15:0]    direction_x,
  input  logic signed [15:0]    direction_y,
  input  logic signed [15:0]    direction_z,
  input  logic [15:0]           ray_tag,
  output logic                  done,
  output logic                  hit,
  output logic [31:0]           distance,
  output logic [15:0]           bary_u,
  output logic [15:0]           bary_v,
  output logic [15:0]           tag_out
);
  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int EW   = CW + 1;
  localparam int HPW  = 2 * CW + 1;
  localparam int HW   = 2 * CW + 2;
  localparam int QPW  = 2 * CW + 2;
  localparam int QW   = 2 * CW + 3;
  localparam int NW   = 3 * CW + 6;
  localparam int MW   = NW + 32;
  localparam int DIVS = TQ_BITS;
  localparam int LAT  = 41;

  logic [3*CW-1:0]   vtx_a, vtx_b, vtx_c;
  logic [EPS_BITS-1:0] eps;
  logic              accept;
  reg_idx_t          widx;

  assign pready = 1'b1;
  assign busy   = rst;
  assign accept = start && !busy;
  assign widx   = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_a <= '0;
      vtx_b <= '0;
      vtx_c <= '0;
      eps   <= EPS_BITS'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_VERTEX_A: vtx_a <= pwdata[3*CW-1:0];
        REG_VERTEX_B: vtx_b <= pwdata[3*CW-1:0];
        REG_VERTEX_C: vtx_c <= pwdata[3*CW-1:0];
        REG_EPSILON:  eps   <= pwdata[EPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_VERTEX_A: prdata = 64'(vtx_a);
      REG_VERTEX_B: prdata = 64'(vtx_b);
      REG_VERTEX_C: prdata = 64'(vtx_c);
      REG_EPSILON:  prdata = 64'(eps);
      default:      prdata = '0;
    endcase
  end

  // edges from the vertex registers
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = vtx_a[i*CW +: CW];
      vb[i] = vtx_b[i*CW +: CW];
      vc[i] = vtx_c[i*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1[i] <= EW'(vb[i]) - EW'(va[i]);
      e2[i] <= EW'(vc[i]) - EW'(va[i]);
    end
  end

  // stage 1: origin offset
  logic [CW+15:0]       ow [3];
  logic [CW+15:0]       dw [3];
  logic [6:0]           vld;
  logic signed [EW-1:0] s1 [3];
  logic signed [CW-1:0] d1 [3];
  logic [IO_BITS-1:0]   tag [7];

  assign ow[0] = {{CW{1'b0}}, origin_x};
  assign ow[1] = {{CW{1'b0}}, origin_y};
  assign ow[2] = {{CW{1'b0}}, origin_z};
  assign dw[0] = {{CW{1'b0}}, direction_x};
  assign dw[1] = {{CW{1'b0}}, direction_y};
  assign dw[2] = {{CW{1'b0}}, direction_z};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1[i] <= EW'($signed(ow[i][CW-1:0])) - EW'(va[i]);
      d1[i] <= $signed(dw[i][CW-1:0]);
    end
    tag[0] <= ray_tag;
    for (int k = 1; k < 7; k++) tag[k] <= tag[k-1];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[5:0], accept};
  end

  // stage 2: cross-product terms
  logic signed [HPW-1:0] hp [6];
  logic signed [QPW-1:0] qp [6];
  logic signed [EW-1:0]  s2 [3];
  logic signed [CW-1:0]  d2 [3];

  always_ff @(posedge clk) begin
    hp[0] <= HPW'(d1[1]) * HPW'(e2[2]);
    hp[1] <= HPW'(d1[2]) * HPW'(e2[1]);
    hp[2] <= HPW'(d1[2]) * HPW'(e2[0]);
    hp[3] <= HPW'(d1[0]) * HPW'(e2[2]);
    hp[4] <= HPW'(d1[0]) * HPW'(e2[1]);
    hp[5] <= HPW'(d1[1]) * HPW'(e2[0]);
    qp[0] <= QPW'(s1[1]) * QPW'(e1[2]);
    qp[1] <= QPW'(s1[2]) * QPW'(e1[1]);
    qp[2] <= QPW'(s1[2]) * QPW'(e1[0]);
    qp[3] <= QPW'(s1[0]) * QPW'(e1[2]);
    qp[4] <= QPW'(s1[0]) * QPW'(e1[1]);
    qp[5] <= QPW'(s1[1]) * QPW'(e1[0]);
    s2 <= s1;
    d2 <= d1;
  end

  // stage 3: cross products
  logic signed [HW-1:0] h3 [3];
  logic signed [QW-1:0] q3 [3];
  logic signed [EW-1:0] s3 [3];
  logic signed [CW-1:0] d3 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      h3[i] <= HW'(hp[2*i]) - HW'(hp[2*i+1]);
      q3[i] <= QW'(qp[2*i]) - QW'(qp[2*i+1]);
    end
    s3 <= s2;
    d3 <= d2;
  end

  // stage 4: dot-product terms
  logic signed [NW-1:0] dp [3];
  logic signed [NW-1:0] up [3];
  logic signed [NW-1:0] vp [3];
  logic signed [NW-1:0] tp [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dp[i] <= NW'(h3[i]) * NW'(e1[i]);
      up[i] <= NW'(s3[i]) * NW'(h3[i]);
      vp[i] <= NW'(q3[i]) * NW'(d3[i]);
      tp[i] <= NW'(q3[i]) * NW'(e2[i]);
    end
  end

  // stage 5: sums
  logic signed [NW-1:0] det5, un5, vn5, tn5;

  always_ff @(posedge clk) begin
    det5 <= dp[0] + dp[1] + dp[2];
    un5  <= up[0] + up[1] + up[2];
    vn5  <= vp[0] + vp[1] + vp[2];
    tn5  <= tp[0] + tp[1] + tp[2];
  end

  // stage 6: fold the determinant sign
  logic signed [NW-1:0] det6, un6, vn6, tn6;

  always_ff @(posedge clk) begin
    if (det5[NW-1]) begin
      det6 <= -det5;
      un6  <= -un5;
      vn6  <= -vn5;
      tn6  <= -tn5;
    end else begin
      det6 <= det5;
      un6  <= un5;
      vn6  <= vn5;
      tn6  <= tn5;
    end
  end

  // stage 7: range tests and epsilon scaling
  logic signed [NW-1:0] det7, un7, vn7, tn7;
  logic [MW-1:0]        eps_det;
  logic                 reject7;

  always_ff @(posedge clk) begin
    det7    <= det6;
    un7     <= un6;
    vn7     <= vn6;
    tn7     <= tn6;
    eps_det <= MW'($unsigned(det6)) * MW'(eps);
    reject7 <= (det6 == '0)
            || (MW'($unsigned(det6)) < (MW'(eps) << (2 * FB)))
            || un6[NW-1] || (un6 > det6)
            || vn6[NW-1]
            || ((NW+1)'(un6) + (NW+1)'(vn6) > (NW+1)'(det6))
            || tn6[NW-1];
  end

  // stage 8 and division stages
  logic [NW-1:0]        dv  [DIVS+1];
  logic [NW-1:0]        rt  [DIVS+1];
  logic [NW-1:0]        ru  [DIVS+1];
  logic [NW-1:0]        rv  [DIVS+1];
  logic [TQ_BITS-1:0]   nt  [DIVS+1];
  logic [UQ_BITS-1:0]   nu  [DIVS+1];
  logic [UQ_BITS-1:0]   nv  [DIVS+1];
  logic [TQ_BITS-1:0]   qt  [DIVS+1];
  logic [UQ_BITS-1:0]   qu  [DIVS+1];
  logic [UQ_BITS-1:0]   qv  [DIVS+1];
  logic [DIVS:0]        hv;
  logic [DIVS:0]        sat;
  logic [IO_BITS-1:0]   dtag [DIVS+1];
  logic [DIVS:0]        dvld;
  logic                 hit8;
  logic                 fit8;
  logic [NW-1:0]        tsh;

  assign tsh  = $unsigned(tn7) >> 16;
  assign hit8 = !reject7 && ((MW'($unsigned(tn7)) << FB) > eps_det);
  assign fit8 = tsh < $unsigned(det7);

  always_ff @(posedge clk) begin
    if (rst) dvld <= '0;
    else begin
      dvld[0] <= vld[6];
      for (int k = 1; k <= DIVS; k++) dvld[k] <= dvld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [NW-1:0] r2;
    dv[0]   <= $unsigned(det7);
    hv[0]   <= hit8;
    sat[0]  <= hit8 && !fit8;
    rt[0]   <= (hit8 && fit8) ? tsh : '0;
    ru[0]   <= hit8 ? ($unsigned(un7) >> 1) : '0;
    rv[0]   <= hit8 ? ($unsigned(vn7) >> 1) : '0;
    nt[0]   <= {tn7[15:0], 16'b0};
    nu[0]   <= {un7[0], {(UQ_BITS-1){1'b0}}};
    nv[0]   <= {vn7[0], {(UQ_BITS-1){1'b0}}};
    qt[0]   <= '0;
    qu[0]   <= '0;
    qv[0]   <= '0;
    dtag[0] <= tag[6];
    for (int k = 1; k <= DIVS; k++) begin
      dv[k]   <= dv[k-1];
      hv[k]   <= hv[k-1];
      sat[k]  <= sat[k-1];
      dtag[k] <= dtag[k-1];
      nt[k]   <= nt[k-1] << 1;
      r2 = {rt[k-1][NW-2:0], nt[k-1][TQ_BITS-1]};
      if (r2 >= dv[k-1]) begin
        rt[k] <= r2 - dv[k-1];
        qt[k] <= {qt[k-1][TQ_BITS-2:0], 1'b1};
      end else begin
        rt[k] <= r2;
        qt[k] <= {qt[k-1][TQ_BITS-2:0], 1'b0};
      end
      if (k <= UQ_BITS) begin
        nu[k] <= nu[k-1] << 1;
        nv[k] <= nv[k-1] << 1;
        r2 = {ru[k-1][NW-2:0], nu[k-1][UQ_BITS-1]};
        if (r2 >= dv[k-1]) begin
          ru[k] <= r2 - dv[k-1];
          qu[k] <= {qu[k-1][UQ_BITS-2:0], 1'b1};
        end else begin
          ru[k] <= r2;
          qu[k] <= {qu[k-1][UQ_BITS-2:0], 1'b0};
        end
        r2 = {rv[k-1][NW-2:0], nv[k-1][UQ_BITS-1]};
        if (r2 >= dv[k-1]) begin
          rv[k] <= r2 - dv[k-1];
          qv[k] <= {qv[k-1][UQ_BITS-2:0], 1'b1};
        end else begin
          rv[k] <= r2;
          qv[k] <= {qv[k-1][UQ_BITS-2:0], 1'b0};
        end
      end else begin
        nu[k] <= nu[k-1];
        nv[k] <= nv[k-1];
        ru[k] <= ru[k-1];
        rv[k] <= rv[k-1];
        qu[k] <= qu[k-1];
        qv[k] <= qv[k-1];
      end
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dvld[DIVS];
    hit      <= hv[DIVS];
    distance <= !hv[DIVS] ? '0 : (sat[DIVS] ? '1 : qt[DIVS]);
    bary_u   <= hv[DIVS] ? qu[DIVS] : '0;
    bary_v   <= hv[DIVS] ? qv[DIVS] : '0;
    tag_out  <= dtag[DIVS];
  end

  `RTI_ASSERT_ALWAYS(a_latency, done == $past(accept, LAT), "result beat out of step")
  `RTI_ASSERT_IMP(a_miss_zero, done && !hit, distance == '0 && bary_u == '0 && bary_v == '0, "miss carries data")
  `RTI_ASSERT_IMP(a_bary_sum, done, (17'(bary_u) + 17'(bary_v)) <= 17'd32768, "barycentric sum above one")
endmodule

// File: sim/ray_triangle_intersect_tb.sv
// Self-checking testbench for the ray/triangle intersection block.
`timescale 1ns / 100ps

module ray_triangle_intersect_tb
  import rti_pkg::*;
();

  typedef struct packed {
    logic signed [15:0] ox, oy, oz, dx, dy, dz;
    logic [15:0]        tag;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] tval;
    logic [15:0] u, v, tag;
  } hit_t;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [15:0] direction_x = '0, direction_y = '0, direction_z = '0;
  logic [15:0] ray_tag = '0;
  logic done, hit;
  logic [31:0] distance;
  logic [15:0] bary_u, bary_v, tag_out;

  ray_t pending_rays[$];
  hit_t expected_hits[$];
  logic [47:0] vtx[3];
  logic [15:0] eps_q;
  bit no_gaps = 0;
  int mismatches = 0;

  ray_triangle_intersect dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .direction_x(direction_x), .direction_y(direction_y), .direction_z(direction_z),
    .ray_tag(ray_tag), .done(done), .hit(hit), .distance(distance),
    .bary_u(bary_u), .bary_v(bary_v), .tag_out(tag_out)
  );

  always #2 clk = ~clk;

  function automatic wide_t coord(logic [47:0] p, int i);
    return wide_t'($signed(p[16*i +: 16]));
  endfunction

  function automatic hit_t predict(ray_t r);
    wide_t a[3], o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
    wide_t det, un, vn, tn, quo, epsw;
    hit_t res;
    res = '0;
    res.tag = r.tag;
    epsw = wide_t'({1'b0, eps_q});
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    for (int i = 0; i < 3; i++) begin
      a[i] = coord(vtx[0], i);
      e1[i] = coord(vtx[1], i) - a[i];
      e2[i] = coord(vtx[2], i) - a[i];
      s[i] = o[i] - a[i];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = h[0] * e1[0] + h[1] * e1[1] + h[2] * e1[2];
    un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vn = q[0] * d[0] + q[1] * d[1] + q[2] * d[2];
    tn = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (det == 0 || det < (epsw <<< 16)) return res;
    if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0) return res;
    if ((tn <<< 8) <= det * epsw) return res;
    res.hit = 1'b1;
    quo = (tn <<< 16) / det;
    res.tval = (quo > 128'sh FFFFFFFF) ? 32'hFFFFFFFF : quo[31:0];
    quo = (un <<< 15) / det;
    res.u = quo[15:0];
    quo = (vn <<< 15) / det;
    res.v = quo[15:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_hits.push_back(predict(pending_rays.pop_front()));
      end
      if (pending_rays.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 23)) begin
        start <= 1'b1;
        origin_x <= pending_rays[0].ox;
        origin_y <= pending_rays[0].oy;
        origin_z <= pending_rays[0].oz;
        direction_x <= pending_rays[0].dx;
        direction_y <= pending_rays[0].dy;
        direction_z <= pending_rays[0].dz;
        ray_tag <= pending_rays[0].tag;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_t got, want;
    if (!rst && done) begin
      got = '{hit, distance, bary_u, bary_v, tag_out};
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = expected_hits.pop_front();
        if (got.hit !== want.hit || got.tval !== want.tval || got.u !== want.u ||
            got.v !== want.v || got.tag !== want.tag) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_EPSILON) eps_q = value[15:0];
    else vtx[idx] = value[47:0];
  endtask

  task automatic set_scene(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                           logic [15:0] e);
    reg_write(REG_VERTEX_A, {$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF | 64'(a));
    reg_write(REG_VERTEX_B, 64'(b));
    reg_write(REG_VERTEX_C, 64'(c));
    reg_write(REG_EPSILON, {48'h0, e});
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || expected_hits.size() > 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] rand_vertex();
    return pack3($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                 $urandom_range(0, 8000) - 4000);
  endfunction

  function automatic ray_t aimed_ray();
    ray_t r;
    int o[3], p[3], dv[3], wu, wv, sh;
    wu = $urandom_range(0, 300);
    wv = $urandom_range(0, 300 - wu);
    sh = $urandom_range(0, 7);
    for (int i = 0; i < 3; i++) begin
      o[i] = $urandom_range(0, 16000) - 8000;
      p[i] = int'(coord(vtx[0], i)) +
             (wu * int'(coord(vtx[1], i) - coord(vtx[0], i)) +
              wv * int'(coord(vtx[2], i) - coord(vtx[0], i))) / 256;
      dv[i] = (p[i] - o[i]) >>> sh;
      if (dv[i] > 32767) dv[i] = 32767;
      if (dv[i] < -32768) dv[i] = -32768;
    end
    r = '{16'(o[0]), 16'(o[1]), 16'(o[2]), 16'(dv[0]), 16'(dv[1]), 16'(dv[2]),
          16'($urandom)};
    return r;
  endfunction

  task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz, int tag);
    pending_rays.push_back('{16'(ox), 16'(oy), 16'(oz), 16'(dx), 16'(dy), 16'(dz),
                             16'(tag)});
  endtask

  initial begin
    vtx[0] = '0; vtx[1] = '0; vtx[2] = '0;
    eps_q = 16'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // degenerate reset triangle
    add_ray(0, 0, 0, 256, 256, 256, 0);
    drain();

    set_scene(pack3(-1024, -1024, 512), pack3(1024, -1024, 512),
              pack3(-1024, 1024, 512), 16'd1);
    add_ray(0, 0, 0, 0, 0, 256, 32'hFFFF);
    add_ray(0, 0, 0, -1024, -1024, 512, 1);
    add_ray(0, 0, 0, 1024, -1024, 512, 2);
    add_ray(0, 0, 0, -1024, 1024, 512, 3);
    add_ray(0, 0, 0, 0, 0, 512, 4);
    add_ray(0, 0, 0, 1025, 0, 512, 5);
    add_ray(0, 0, 0, 256, 0, 0, 6);
    add_ray(0, 0, 0, 0, 0, -256, 7);
    add_ray(0, 0, 0, 0, 0, 0, 8);
    add_ray(0, 0, 511, 0, 0, 1, 9);
    add_ray(0, 0, 511, 0, 0, 256, 10);
    add_ray(0, 0, -32768, 0, 0, 1, 11);
    add_ray(-32768, -32768, -32768, 32767, 32767, 32767, 12);
    add_ray(32767, 32767, 32767, -32768, -32768, -32768, 13);
    add_ray(-32768, 32767, -32768, 32767, -32768, 32767, 14);
    add_ray(0, 0, 0, -1100, -1100, 512, 15);
    drain();

    set_scene(pack3(-32768, -32768, 32767), pack3(32767, -32768, 32767),
              pack3(-32768, 32767, 32767), 16'd0);
    add_ray(0, 0, -32768, 0, 0, 1, 16);
    add_ray(0, 0, -32768, 0, 0, 32767, 17);
    add_ray(0, 0, 32767, 0, 0, 256, 18);
    add_ray(0, 0, 0, 256, 0, 0, 19);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      logic [15:0] e;
      case (phase)
        0: e = 16'd0;
        1: e = 16'd1;
        2: e = 16'hFFFF;
        3: e = 16'd4;
        default: e = 16'($urandom_range(0, 64));
      endcase
      if (phase == 7)
        set_scene(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 16'($urandom));
      else
        set_scene(rand_vertex(), rand_vertex(), rand_vertex(), e);
      no_gaps = (phase == 3);
      for (int n = 0; n < 235; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          pending_rays.push_back(aimed_ray());
        end else begin
          pending_rays.push_back('{16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom)});
        end
      end
      drain();
    end

    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("ray_triangle_intersect_tb: done, clean");
    end else begin
      $display("ray_triangle_intersect_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ray_triangle_intersect_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rti_pkg.sv
rtl/ray_triangle_intersect.sv
sim/ray_triangle_intersect_tb.sv
